/* src/lvns_pkg.sv */
// Shared types, widths and codes of the lattice value-noise sampler.
package lvns_pkg;

	localparam int TABLE_SIZE_DEF      = 512;
	localparam int COORD_FRAC_BITS_DEF = 16;

	localparam int COORD_W   = 17;
	localparam int ROW_W     = 9;
	localparam int VALUE_W   = 16;
	localparam int NOISE_W   = 17;
	localparam int FRAC_W    = 16;
	localparam int OCT_CNT_W = 4;
	localparam int OCT_W     = 3;
	localparam int MAX_OCTAVES = 8;
	localparam int OCT_VAL_W = 48;
	localparam int ACC_W     = 49;

	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	// corner order of the four reads: (iu,iv) (iu+1,iv) (iu,iv+1) (iu+1,iv+1)
	typedef enum logic [1:0] {
		CORNER_A = 2'd0,
		CORNER_B = 2'd1,
		CORNER_C = 2'd2,
		CORNER_D = 2'd3
	} corner_t;

	typedef struct packed {
		logic               func;
		logic [COORD_W-1:0] coord_u;
		logic [COORD_W-1:0] coord_v;
		logic [ROW_W-1:0]   entry_row;
		logic [ROW_W-1:0]   entry_col;
		logic [VALUE_W-1:0] entry_value;
	} req_item_t;

	typedef struct packed {
		logic [NOISE_W-1:0] noise_value;
	} rsp_item_t;

	typedef struct packed {
		logic              wr;
		logic [FRAC_W-1:0] du;
		logic [FRAC_W-1:0] dv;
		logic [OCT_W-1:0]  oct;
		corner_t           corner;
		logic              last;
	} beat_ctl_t;

	typedef struct packed {
		logic [VALUE_W-1:0] a;
		logic [VALUE_W-1:0] b;
		logic [VALUE_W-1:0] c;
		logic [VALUE_W-1:0] d;
		logic [FRAC_W-1:0]  du;
		logic [FRAC_W-1:0]  dv;
		logic [OCT_W-1:0]   oct;
		logic               last;
	} lerp_in_t;

	typedef struct packed {
		logic [OCT_VAL_W-1:0] value;
		logic                 first;
		logic                 last;
	} oct_val_t;

endpackage

/* src/lvns_if.sv */
// Valid/ready channel interfaces for sample requests and noise results.
interface lvns_req_if import lvns_pkg::*; ();
	logic      valid;
	logic      ready;
	req_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface lvns_rsp_if import lvns_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* src/lvns_seq.sv */
// Read sequencer: steps octaves and corners, issues one table address per cycle while not stalled.
module lvns_seq import lvns_pkg::*; #(
	parameter int TABLE_SIZE      = TABLE_SIZE_DEF,
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      adv,
	input  logic [OCT_CNT_W-1:0]                      octave_count,
	lvns_req_if.sink                                  req,
	output logic                                      valid_s1,
	output logic [$clog2(TABLE_SIZE*TABLE_SIZE)-1:0]  addr_s1,
	output logic [VALUE_W-1:0]                        wdata_s1,
	output beat_ctl_t                                 ctl_s1
);

	localparam int IDX_W  = $clog2(TABLE_SIZE);
	localparam int ADDR_W = $clog2(TABLE_SIZE * TABLE_SIZE);
	localparam int XW     = (IDX_W > ROW_W) ? IDX_W : ROW_W;
	localparam int F      = COORD_FRAC_BITS;
	localparam int RW     = (F < COORD_W) ? F : COORD_W;
	localparam int TSW    = $clog2(TABLE_SIZE + 1);
	localparam int PW     = F + TSW;

	logic               busy_q;
	logic               wr_q;
	logic               wr_ok_q;
	logic [ROW_W-1:0]   wrow_q;
	logic [ROW_W-1:0]   wcol_q;
	logic [VALUE_W-1:0] wval_q;
	logic [IDX_W-1:0]   iu_q;
	logic [IDX_W-1:0]   iv_q;
	logic [F-1:0]       fu_q;
	logic [F-1:0]       fv_q;
	logic [OCT_W-1:0]   oct_q;
	logic [OCT_W-1:0]   nlast_q;
	corner_t            corner_q;

	logic               accept;
	logic               issue;
	logic               last_issue;
	logic [PW-1:0]      pu0;
	logic [PW-1:0]      pv0;
	logic [IDX_W-1:0]   ip;
	logic [IDX_W-1:0]   iq;
	logic [IDX_W-1:0]   row_sel;
	logic [IDX_W-1:0]   col_sel;
	logic [XW-1:0]      row_x;
	logic [XW-1:0]      col_x;
	logic [ADDR_W-1:0]  addr_n;
	logic [F+15:0]      fu_ext;
	logic [F+15:0]      fv_ext;
	logic [IDX_W:0]     dbl_u;
	logic [IDX_W:0]     dbl_v;
	logic [IDX_W-1:0]   iu_n;
	logic [IDX_W-1:0]   iv_n;
	logic               row_ok;
	logic               col_ok;

	// zero counts as one octave, anything above the maximum as the maximum
	function automatic logic [OCT_W-1:0] last_octave(input logic [OCT_CNT_W-1:0] n);
		logic [OCT_W-1:0] r;
		if (n == '0) begin
			r = '0;
		end else if (n > OCT_CNT_W'(MAX_OCTAVES)) begin
			r = OCT_W'(MAX_OCTAVES - 1);
		end else begin
			r = OCT_W'(n - OCT_CNT_W'(1));
		end
		return r;
	endfunction

	assign issue      = busy_q && adv;
	assign last_issue = wr_q || (corner_q == CORNER_D && oct_q == nlast_q);
	assign req.ready  = adv && (!busy_q || last_issue);
	assign accept     = req.valid && req.ready;

	// octave zero: integer part is already below TABLE_SIZE once the whole part of
	// the coordinate is dropped
	assign pu0 = PW'(req.data.coord_u[RW-1:0]) * PW'(TABLE_SIZE);
	assign pv0 = PW'(req.data.coord_v[RW-1:0]) * PW'(TABLE_SIZE);

	assign row_ok = 32'(req.data.entry_row) < TABLE_SIZE;
	assign col_ok = 32'(req.data.entry_col) < TABLE_SIZE;

	assign ip = (iu_q == IDX_W'(TABLE_SIZE - 1)) ? '0 : iu_q + IDX_W'(1);
	assign iq = (iv_q == IDX_W'(TABLE_SIZE - 1)) ? '0 : iv_q + IDX_W'(1);

	assign row_sel = (corner_q == CORNER_B || corner_q == CORNER_D) ? ip : iu_q;
	assign col_sel = (corner_q == CORNER_C || corner_q == CORNER_D) ? iq : iv_q;
	assign row_x   = wr_q ? XW'(wrow_q) : XW'(row_sel);
	assign col_x   = wr_q ? XW'(wcol_q) : XW'(col_sel);
	assign addr_n  = ADDR_W'(row_x) * ADDR_W'(TABLE_SIZE) + ADDR_W'(col_x);

	assign fu_ext = {fu_q, 16'h0};
	assign fv_ext = {fv_q, 16'h0};

	// next octave doubles the position: shift the top fraction bit into the index
	assign dbl_u = {iu_q, fu_q[F-1]};
	assign dbl_v = {iv_q, fv_q[F-1]};
	assign iu_n  = (dbl_u >= (IDX_W+1)'(TABLE_SIZE)) ?
		IDX_W'(dbl_u - (IDX_W+1)'(TABLE_SIZE)) : IDX_W'(dbl_u);
	assign iv_n  = (dbl_v >= (IDX_W+1)'(TABLE_SIZE)) ?
		IDX_W'(dbl_v - (IDX_W+1)'(TABLE_SIZE)) : IDX_W'(dbl_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			corner_q <= CORNER_A;
			oct_q    <= '0;
		end else if (accept) begin
			busy_q   <= 1'b1;
			corner_q <= CORNER_A;
			oct_q    <= '0;
		end else if (issue) begin
			if (last_issue) begin
				busy_q <= 1'b0;
			end else begin
				corner_q <= corner_t'(2'(corner_q + 2'd1));
				if (corner_q == CORNER_D) begin
					oct_q <= oct_q + OCT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wr_q    <= (req.data.func == FUNC_WRITE);
			wr_ok_q <= row_ok && col_ok;
			wrow_q  <= req.data.entry_row;
			wcol_q  <= req.data.entry_col;
			wval_q  <= req.data.entry_value;
			nlast_q <= last_octave(octave_count);
			iu_q    <= IDX_W'(pu0 >> F);
			iv_q    <= IDX_W'(pv0 >> F);
			fu_q    <= pu0[F-1:0];
			fv_q    <= pv0[F-1:0];
		end else if (issue && !last_issue && corner_q == CORNER_D) begin
			iu_q <= iu_n;
			iv_q <= iv_n;
			fu_q <= {fu_q[F-2:0], 1'b0};
			fv_q <= {fv_q[F-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			// drop writes that fall outside the table
			valid_s1 <= issue && (!wr_q || wr_ok_q);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s1       <= addr_n;
			wdata_s1      <= wval_q;
			ctl_s1.wr     <= wr_q;
			ctl_s1.du     <= fu_ext[F+15:F];
			ctl_s1.dv     <= fv_ext[F+15:F];
			ctl_s1.oct    <= oct_q;
			ctl_s1.corner <= corner_q;
			ctl_s1.last   <= (oct_q == nlast_q);
		end
	end

	a_no_accept_mid_item: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !last_issue |-> !req.ready)
		else $error("new beat taken while reads of the current item remain");

	a_octave_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> oct_q <= nlast_q)
		else $error("octave index past the last octave");

	a_write_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && wr_q && adv && !req.valid |=> !busy_q)
		else $error("write item held the sequencer for more than one cycle");

endmodule

/* src/lvns_lerp.sv */
// Bilinear interpolation pipeline: u-axis lerp, v-axis lerp and octave weighting.
module lvns_lerp import lvns_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  logic     valid_s3,
	input  lerp_in_t in_s3,
	output logic     valid_s5,
	output oct_val_t out_s5
);

	logic                 valid_s4;
	logic [31:0]          bot_s4;
	logic [31:0]          top_s4;
	logic [FRAC_W-1:0]    dv_s4;
	logic [OCT_W-1:0]     oct_s4;
	logic                 last_s4;

	logic signed [16:0]   du_sg;
	logic signed [16:0]   diff_ab;
	logic signed [16:0]   diff_cd;
	logic signed [33:0]   bot_n;
	logic signed [33:0]   top_n;
	logic signed [32:0]   diff_tb;
	logic signed [32:0]   dv_sg;
	logic signed [49:0]   val_n;
	logic [OCT_VAL_W-1:0] val_w;

	// a*(1-du) + b*du rewritten as a*2^16 + (b-a)*du: one multiplier per row
	assign du_sg   = $signed({1'b0, in_s3.du});
	assign diff_ab = $signed({1'b0, in_s3.b}) - $signed({1'b0, in_s3.a});
	assign diff_cd = $signed({1'b0, in_s3.d}) - $signed({1'b0, in_s3.c});
	assign bot_n   = $signed({2'b00, in_s3.a, 16'h0}) + diff_ab * du_sg;
	assign top_n   = $signed({2'b00, in_s3.c, 16'h0}) + diff_cd * du_sg;

	assign dv_sg   = $signed({17'h0, dv_s4});
	assign diff_tb = $signed({1'b0, top_s4}) - $signed({1'b0, bot_s4});
	assign val_n   = $signed({2'b00, bot_s4, 16'h0}) + diff_tb * dv_sg;
	assign val_w   = val_n[OCT_VAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bot_s4       <= bot_n[31:0];
			top_s4       <= top_n[31:0];
			dv_s4        <= in_s3.dv;
			oct_s4       <= in_s3.oct;
			last_s4      <= in_s3.last;
			// weight octave k by 2^-k
			out_s5.value <= val_w >> oct_s4;
			out_s5.first <= (oct_s4 == '0);
			out_s5.last  <= last_s4;
		end
	end

endmodule

/* src/lattice_value_noise_sampler_top.sv */
// Lattice value-noise sampler top level: table memory, corner collection, octave sum.
//
// A write item loads one 16-bit entry of the TABLE_SIZE x TABLE_SIZE noise table and
// frees the input as its write issues; writes outside the table are dropped. A sample
// item holds the input until its last read issues (octave_count taken as 1..8):
// the table is a single-ported memory and each octave reads its four lattice
// corners through that one port, one per cycle while not stalled. Behind the read
// port the interpolation runs as a pipeline (read, collect, u-lerp, v-lerp and
// weight, accumulate), so the result of a sample is offered once its last read has
// passed these stages, while the next item already issues reads. A result left
// waiting on the output stalls everything once the next sum completes. The table
// has no reset and no clearing pass: sample only coordinates whose corners were
// written. octave_count is sampled when a sample item is taken and may be written
// only while the block is idle.
module lattice_value_noise_sampler_top import lvns_pkg::*; #(
	parameter int TABLE_SIZE      = TABLE_SIZE_DEF,
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [OCT_CNT_W-1:0] cfg_wdata,
	lvns_req_if.sink             req,
	lvns_rsp_if.source           rsp
);

	localparam int ADDR_W = $clog2(TABLE_SIZE * TABLE_SIZE);
	localparam int DEPTH  = TABLE_SIZE * TABLE_SIZE;

	logic [VALUE_W-1:0]   mem [DEPTH];

	logic [OCT_CNT_W-1:0] octave_q;
	logic                 adv;

	logic                 valid_s1;
	logic [ADDR_W-1:0]    addr_s1;
	logic [VALUE_W-1:0]   wdata_s1;
	beat_ctl_t            ctl_s1;

	logic                 valid_s2;
	logic [VALUE_W-1:0]   rdata_s2;
	beat_ctl_t            ctl_s2;

	logic [VALUE_W-1:0]   ca_q;
	logic [VALUE_W-1:0]   cb_q;
	logic [VALUE_W-1:0]   cc_q;
	logic                 valid_s3;
	lerp_in_t             lerp_s3;

	logic                 valid_s5;
	oct_val_t             oct_s5;

	logic [ACC_W-1:0]     acc_q;
	logic [ACC_W-1:0]     sum_n;
	logic                 out_valid_q;
	rsp_item_t            out_q;

	// stall only when a finished sum would land on an untaken result
	assign adv = !(out_valid_q && !rsp.ready && valid_s5 && oct_s5.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_q <= OCT_CNT_W'(1);
		end else if (cfg_we) begin
			octave_q <= cfg_wdata;
		end
	end

	lvns_seq #(
		.TABLE_SIZE      (TABLE_SIZE),
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.octave_count (octave_q),
		.req          (req),
		.valid_s1     (valid_s1),
		.addr_s1      (addr_s1),
		.wdata_s1     (wdata_s1),
		.ctl_s1       (ctl_s1)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (valid_s1 && ctl_s1.wr) begin
				mem[addr_s1] <= wdata_s1;
			end
			rdata_s2 <= mem[addr_s1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			// writes end at the memory
			valid_s2 <= valid_s1 && !ctl_s1.wr;
			valid_s3 <= valid_s2 && ctl_s2.corner == CORNER_D;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2 <= ctl_s1;
		end
	end

	// gather the four corners; the last one releases the set
	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			unique case (ctl_s2.corner)
				CORNER_A: begin
					ca_q <= rdata_s2;
				end
				CORNER_B: begin
					cb_q <= rdata_s2;
				end
				CORNER_C: begin
					cc_q <= rdata_s2;
				end
				CORNER_D: begin
					lerp_s3.a    <= ca_q;
					lerp_s3.b    <= cb_q;
					lerp_s3.c    <= cc_q;
					lerp_s3.d    <= rdata_s2;
					lerp_s3.du   <= ctl_s2.du;
					lerp_s3.dv   <= ctl_s2.dv;
					lerp_s3.oct  <= ctl_s2.oct;
					lerp_s3.last <= ctl_s2.last;
				end
				default: begin
					ca_q <= ca_q;
				end
			endcase
		end
	end

	lvns_lerp u_lerp (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s3 (valid_s3),
		.in_s3    (lerp_s3),
		.valid_s5 (valid_s5),
		.out_s5   (oct_s5)
	);

	assign sum_n = (oct_s5.first ? '0 : acc_q) + ACC_W'(oct_s5.value);

	always_ff @(posedge clk) begin
		if (adv && valid_s5) begin
			acc_q <= sum_n;
			if (oct_s5.last) begin
				// the weighted sum stays below 2^49, so its top 17 bits never overflow
				out_q.noise_value <= sum_n[ACC_W-1:ACC_W-NOISE_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && valid_s5 && oct_s5.last) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	a_result_from_last_octave: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s5 && oct_s5.last))
		else $error("result raised without a final-octave beat");

	a_stall_freezes_tail: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(valid_s5) && $stable(acc_q))
		else $error("accumulator stage moved during a stall");

	a_set_after_corner_d: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s3) |-> $past(valid_s2 && ctl_s2.corner == CORNER_D))
		else $error("corner set released before its fourth read");

endmodule
